// ===== rtl/pckmb_pkg.sv =====
// shared types and constants for the color keyed palette blit
`timescale 1ns / 1ps
package pckmb_pkg;

  localparam int AddrW       = 20;
  localparam int ColorW      = 8;
  localparam int IdxW        = 8;
  localparam int PalDepth    = 256;
  localparam int PalAddrW    = $clog2(PalDepth);
  localparam int KeyW        = 4;
  localparam int PosW        = 10;
  localparam int DimRegW     = 11;
  localparam int DataW       = 32;
  localparam int PaddrW      = 5;
  localparam int MaxDimDefault = 1024;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdPixel = 1'b1;

  localparam logic [DimRegW-1:0] RectWidthRst  = 11'd1;
  localparam logic [DimRegW-1:0] RectHeightRst = 11'd1;
  localparam logic [DimRegW-1:0] DestStrideRst = 11'd1024;

  typedef enum logic [2:0] {
    REG_DEST_X      = 3'd0,
    REG_DEST_Y      = 3'd1,
    REG_RECT_WIDTH  = 3'd2,
    REG_RECT_HEIGHT = 3'd3,
    REG_DEST_STRIDE = 3'd4,
    REG_MIRROR      = 3'd5,
    REG_KEY_ENABLE  = 3'd6,
    REG_KEY_INDEX   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [PosW-1:0]    dest_x;
    logic [PosW-1:0]    dest_y;
    logic [DimRegW-1:0] rect_width;
    logic [DimRegW-1:0] rect_height;
    logic [DimRegW-1:0] dest_stride;
    logic               mirror;
    logic               key_enable;
    logic [KeyW-1:0]    key_index;
  } cfg_t;

  typedef struct packed {
    logic pix_accept;
    logic advance;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [AddrW-1:0] dest_address;
    logic             write_enable;
    logic             last;
  } pix_res_t;

endpackage

// ===== rtl/pckmb_palette_mem.sv =====
// palette table: one write port, one registered read port
`timescale 1ns / 1ps
module pckmb_palette_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [pckmb_pkg::PalAddrW-1:0] waddr_i,
  input  logic [pckmb_pkg::ColorW-1:0]   wdata_i,
  input  logic                           re_i,
  input  logic [pckmb_pkg::PalAddrW-1:0] raddr_i,
  output logic [pckmb_pkg::ColorW-1:0]   rdata_o
);

  logic [pckmb_pkg::ColorW-1:0] mem [pckmb_pkg::PalDepth];
  logic [pckmb_pkg::ColorW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no pixel is taken, so a stalled stage keeps its color
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pckmb_addr_gen.sv =====
// rectangle position counters and destination address stage
`timescale 1ns / 1ps
module pckmb_addr_gen #(
  parameter int MaxDim = pckmb_pkg::MaxDimDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pckmb_pkg::cfg_t            cfg_i,
  input  pckmb_pkg::pipe_ctrl_t      ctrl_i,
  input  logic [pckmb_pkg::IdxW-1:0] pixel_index_i,
  output pckmb_pkg::pix_res_t        res_o
);

  localparam int AW   = pckmb_pkg::AddrW;
  localparam int CntW = $clog2(MaxDim);
  localparam int DimW = $clog2(MaxDim + 1);
  localparam int CmpW = (DimW > pckmb_pkg::DimRegW) ? DimW : pckmb_pkg::DimRegW;
  localparam int ProdW = pckmb_pkg::PosW + pckmb_pkg::DimRegW;

  logic [CntW-1:0]  col_q, col_d;
  logic [CntW-1:0]  row_q, row_d;
  logic [AW-1:0]    row_base_q, row_base_d;
  logic [AW-1:0]    top_q;
  logic [ProdW-1:0] top_prod;

  logic [AW-1:0] s1_dcol_q;
  logic [AW-1:0] s1_base_q;
  logic          s1_we_q;
  logic          s1_last_q;

  logic [CmpW-1:0] width_raw, height_raw, width_c, height_c;
  logic [AW-1:0]   col_ext, col_next, row_next, dcol;
  logic            col_end, row_end, last_d, we_d;

  assign width_raw  = CmpW'(cfg_i.rect_width);
  assign height_raw = CmpW'(cfg_i.rect_height);

  // zero counts as one, oversize saturates
  always_comb begin
    if (width_raw == '0) begin
      width_c = CmpW'(1);
    end else if (width_raw > CmpW'(MaxDim)) begin
      width_c = CmpW'(MaxDim);
    end else begin
      width_c = width_raw;
    end
    if (height_raw == '0) begin
      height_c = CmpW'(1);
    end else if (height_raw > CmpW'(MaxDim)) begin
      height_c = CmpW'(MaxDim);
    end else begin
      height_c = height_raw;
    end
  end

  assign col_ext  = AW'(col_q);
  assign col_next = col_ext + AW'(1);
  assign row_next = AW'(row_q) + AW'(1);
  assign col_end  = col_next >= AW'(width_c);
  assign row_end  = row_next >= AW'(height_c);
  // mirrored column wraps if the width shrank under the counter
  assign dcol     = cfg_i.mirror ? (AW'(width_c) - AW'(1) - col_ext) : col_ext;
  assign we_d     = !(cfg_i.key_enable &&
                      (pixel_index_i == pckmb_pkg::IdxW'(cfg_i.key_index)));

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    last_d     = 1'b0;
    if (ctrl_i.pix_accept) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          last_d     = 1'b1;
          row_d      = '0;
          row_base_d = '0;
        end else begin
          row_d      = CntW'(row_next);
          row_base_d = row_base_q + AW'(cfg_i.dest_stride);
        end
      end else begin
        col_d = CntW'(col_next);
      end
    end
  end

  assign top_prod = ProdW'(cfg_i.dest_y) * ProdW'(cfg_i.dest_stride);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
      top_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
      top_q      <= top_prod[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pix_accept) begin
      s1_dcol_q <= dcol;
      s1_base_q <= row_base_q;
      s1_we_q   <= we_d;
      s1_last_q <= last_d;
    end
  end

  assign res_o.dest_address = top_q + s1_base_q + AW'(cfg_i.dest_x) + s1_dcol_q;
  assign res_o.write_enable = s1_we_q;
  assign res_o.last         = s1_last_q;

endmodule

// ===== rtl/palette_color_key_mirror_blit.sv =====
// top level: config registers, handshake, palette lookup and output register
// a pixel is accepted, reads the palette and forms its address in the
// next cycle, and its result then moves into the output register once that register is free
// throughput: one item per cycle unless out_ready_i stalls, set by the single palette read port and the counters
// palette loads give no result
// reset clears the position counters and valid flags and sets config register defaults; palette is unset
`timescale 1ns / 1ps
module palette_color_key_mirror_blit #(
  parameter int MaxDim = pckmb_pkg::MaxDimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pckmb_pkg::PaddrW-1:0]  paddr,
  input  logic [pckmb_pkg::DataW-1:0]   pwdata,
  output logic [pckmb_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [pckmb_pkg::IdxW-1:0]    pixel_index_i,
  input  logic [pckmb_pkg::ColorW-1:0]  palette_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pckmb_pkg::AddrW-1:0]   dest_address_o,
  output logic [pckmb_pkg::ColorW-1:0]  color_o,
  output logic                          write_enable_o,
  output logic                          last_o
);

  localparam int DW = pckmb_pkg::DataW;

  pckmb_pkg::cfg_t       cfg_q, cfg_d;
  pckmb_pkg::cfg_reg_e   reg_sel;
  pckmb_pkg::pipe_ctrl_t ctrl;
  pckmb_pkg::pix_res_t   s1_res;

  logic cfg_wr;
  logic in_fire, pix_fire, load_fire;
  logic s1_valid_q, s1_valid_d, s1_adv;
  logic out_valid_q, out_valid_d;
  logic [pckmb_pkg::ColorW-1:0] s1_color;

  logic [pckmb_pkg::AddrW-1:0]  out_addr_q;
  logic [pckmb_pkg::ColorW-1:0] out_color_q;
  logic                         out_we_q;
  logic                         out_last_q;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = pckmb_pkg::cfg_reg_e'(paddr[4:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_sel)
        pckmb_pkg::REG_DEST_X:      cfg_d.dest_x      = pwdata[pckmb_pkg::PosW-1:0];
        pckmb_pkg::REG_DEST_Y:      cfg_d.dest_y      = pwdata[pckmb_pkg::PosW-1:0];
        pckmb_pkg::REG_RECT_WIDTH:  cfg_d.rect_width  = pwdata[pckmb_pkg::DimRegW-1:0];
        pckmb_pkg::REG_RECT_HEIGHT: cfg_d.rect_height = pwdata[pckmb_pkg::DimRegW-1:0];
        pckmb_pkg::REG_DEST_STRIDE: cfg_d.dest_stride = pwdata[pckmb_pkg::DimRegW-1:0];
        pckmb_pkg::REG_MIRROR:      cfg_d.mirror      = pwdata[0];
        pckmb_pkg::REG_KEY_ENABLE:  cfg_d.key_enable  = pwdata[0];
        pckmb_pkg::REG_KEY_INDEX:   cfg_d.key_index   = pwdata[pckmb_pkg::KeyW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pckmb_pkg::REG_DEST_X:      prdata = DW'(cfg_q.dest_x);
      pckmb_pkg::REG_DEST_Y:      prdata = DW'(cfg_q.dest_y);
      pckmb_pkg::REG_RECT_WIDTH:  prdata = DW'(cfg_q.rect_width);
      pckmb_pkg::REG_RECT_HEIGHT: prdata = DW'(cfg_q.rect_height);
      pckmb_pkg::REG_DEST_STRIDE: prdata = DW'(cfg_q.dest_stride);
      pckmb_pkg::REG_MIRROR:      prdata = DW'(cfg_q.mirror);
      pckmb_pkg::REG_KEY_ENABLE:  prdata = DW'(cfg_q.key_enable);
      pckmb_pkg::REG_KEY_INDEX:   prdata = DW'(cfg_q.key_index);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x      <= '0;
      cfg_q.dest_y      <= '0;
      cfg_q.rect_width  <= pckmb_pkg::RectWidthRst;
      cfg_q.rect_height <= pckmb_pkg::RectHeightRst;
      cfg_q.dest_stride <= pckmb_pkg::DestStrideRst;
      cfg_q.mirror      <= 1'b0;
      cfg_q.key_enable  <= 1'b0;
      cfg_q.key_index   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // pipeline handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pix_fire   = in_fire && (cmd_i == pckmb_pkg::CmdPixel);
  assign load_fire  = in_fire && (cmd_i == pckmb_pkg::CmdLoad);

  assign ctrl.pix_accept = pix_fire;
  assign ctrl.advance    = s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  pckmb_palette_mem u_palette (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (pixel_index_i),
    .wdata_i (palette_value_i),
    .re_i    (pix_fire),
    .raddr_i (pixel_index_i),
    .rdata_o (s1_color)
  );

  pckmb_addr_gen #(
    .MaxDim (MaxDim)
  ) u_addr_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .ctrl_i        (ctrl),
    .pixel_index_i (pixel_index_i),
    .res_o         (s1_res)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.advance) begin
      out_addr_q  <= s1_res.dest_address;
      out_color_q <= s1_color;
      out_we_q    <= s1_res.write_enable;
      out_last_q  <= s1_res.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = out_addr_q;
  assign color_o        = out_color_q;
  assign write_enable_o = out_we_q;
  assign last_o         = out_last_q;

  // a pixel transaction always lands in the lookup stage
  a_pix_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_valid_q)
    else $error("pixel accepted but lookup stage empty");

  // a palette load never creates a result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_fire && !s1_valid_q) |=> !s1_valid_q)
    else $error("palette load produced a pending result");

  // output becomes valid only from a filled lookup stage
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q))
    else $error("output valid without a source pixel");

  // lookup stage is never stuck when the output side is free
  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q) |-> in_ready_o)
    else $error("input blocked while output register is empty");

endmodule
